>>> sv/assert_macros.svh
// concurrent assertion helpers, clocked and reset-gated
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/mrc_pkg.sv
package mrc_pkg;

    localparam int KEY_BITS        = 64;
    localparam int SLOT_BITS       = 4;
    localparam int CFG_BITS        = 5;
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_WIDTH   = 64;

    localparam logic [CFG_BITS-1:0] CFG_MAX_RESET = 5'd16;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INVAL  = 1'b1;

    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } t_dp_cmd;

endpackage

>>> sv/mrc_ifs.sv
interface mrc_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [mrc_pkg::KEY_BITS-1:0] lookup_key;

    modport source (output valid, output action, output lookup_key, input ready);
    modport sink   (input valid, input action, input lookup_key, output ready);
endinterface

interface mrc_res_if;
    logic                          valid;
    logic                          ready;
    logic [mrc_pkg::SLOT_BITS-1:0] buffer_slot;
    logic                          hit;

    modport source (output valid, output buffer_slot, output hit, input ready);
    modport sink   (input valid, input buffer_slot, input hit, output ready);
endinterface

interface mrc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mrc_pkg::CFG_BITS-1:0] max_entries;

    modport source (output valid, output max_entries, input ready);
    modport sink   (input valid, input max_entries, output ready);
endinterface

>>> sv/mrc_ctrl.sv
`include "assert_macros.svh"

module mrc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mrc_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_start;
    logic       w_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_start     = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == S_MOVE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_start;
        o_cmd.compare = (r_state == S_CMP);
        o_cmd.commit  = w_commit;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_MOVE;
            end
            S_MOVE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_NEXT(a_start_then_compare, i_clk, i_rst_n, w_start, o_cmd.compare)
    `ASSERT_NEXT(a_compare_then_move, i_clk, i_rst_n, o_cmd.compare, r_state == S_MOVE)
    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, o_cmd.commit, !r_out_valid || i_out_ready)
    `ASSERT_ALWAYS(a_one_cmd, i_clk, i_rst_n, $onehot0({o_cmd.load, o_cmd.compare, o_cmd.commit}))

endmodule

>>> sv/mrc_dp.sv
module mrc_dp #(
    parameter int MAX_ENTRIES = mrc_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_WIDTH   = mrc_pkg::DEF_KEY_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mrc_pkg::t_dp_cmd              i_cmd,
    input  logic                          i_action,
    input  logic [mrc_pkg::KEY_BITS-1:0]  i_lookup_key,
    input  logic                          i_cfg_we,
    input  logic [mrc_pkg::CFG_BITS-1:0]  i_cfg_data,
    output logic [mrc_pkg::SLOT_BITS-1:0] o_buffer_slot,
    output logic                          o_hit
);

    localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > mrc_pkg::CFG_BITS) ? CNT_W : mrc_pkg::CFG_BITS;

    logic [KEY_WIDTH-1:0]        r_key [MAX_ENTRIES];
    logic [POS_W-1:0]            r_slot [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]      r_valid;
    logic [CNT_W-1:0]            r_used;
    logic [mrc_pkg::CFG_BITS-1:0] r_max_entries;
    logic [KEY_WIDTH-1:0]        r_lkey;
    logic                        r_act;
    logic [MAX_ENTRIES-1:0]      r_match;
    logic [MAX_ENTRIES-1:0]      r_free;
    logic [mrc_pkg::SLOT_BITS-1:0] r_out_slot;
    logic                        r_out_hit;

    logic                        w_any_hit;
    logic                        w_any_free;
    logic [POS_W-1:0]            w_hit_pos;
    logic [POS_W-1:0]            w_free_pos;
    logic [CMP_W-1:0]            w_limit;
    logic                        w_create;
    logic [CNT_W-1:0]            w_used_m1;
    logic [POS_W-1:0]            w_pos;
    logic [POS_W-1:0]            w_mslot;
    logic [POS_W+mrc_pkg::SLOT_BITS-1:0] w_slot_ext;

    // priority search, lowest position wins
    always_comb begin
        w_any_hit  = 1'b0;
        w_any_free = 1'b0;
        w_hit_pos  = '0;
        w_free_pos = '0;
        for (int p = MAX_ENTRIES - 1; p >= 0; p--) begin
            if (r_match[p]) begin
                w_any_hit = 1'b1;
                w_hit_pos = POS_W'(p);
            end
            if (r_free[p]) begin
                w_any_free = 1'b1;
                w_free_pos = POS_W'(p);
            end
        end
    end

    // clamped slot limit
    always_comb begin
        w_limit = CMP_W'(r_max_entries);
        if (r_max_entries == '0) begin
            w_limit = CMP_W'(1);
        end
    end

    assign w_create  = !w_any_hit && !w_any_free
                       && (r_used < CNT_W'(MAX_ENTRIES))
                       && (CMP_W'(r_used) < w_limit);
    assign w_used_m1 = r_used - 1'b1;

    always_comb begin
        if (w_any_hit) begin
            w_pos = w_hit_pos;
        end else if (w_any_free) begin
            w_pos = w_free_pos;
        end else if (w_create) begin
            w_pos = r_used[POS_W-1:0];
        end else begin
            w_pos = w_used_m1[POS_W-1:0];
        end
    end

    assign w_mslot    = w_create ? r_used[POS_W-1:0] : r_slot[w_pos];
    assign w_slot_ext = {{mrc_pkg::SLOT_BITS{1'b0}}, w_mslot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= mrc_pkg::CFG_MAX_RESET;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lkey <= i_lookup_key[KEY_WIDTH-1:0];
            r_act  <= i_action;
        end
        if (i_cmd.compare) begin
            for (int p = 0; p < MAX_ENTRIES; p++) begin
                r_match[p] <= r_valid[p] && (r_key[p] == r_lkey);
                r_free[p]  <= !r_valid[p] && (CNT_W'(p) < r_used);
            end
        end
        if (i_cmd.commit) begin
            if (r_act == mrc_pkg::ACT_INVAL) begin
                r_out_slot <= '0;
                r_out_hit  <= 1'b0;
            end else begin
                r_out_slot <= w_slot_ext[mrc_pkg::SLOT_BITS-1:0];
                r_out_hit  <= w_any_hit;
            end
        end
    end

    // key line, move to front
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_act == mrc_pkg::ACT_LOOKUP)) begin
            r_key[0] <= r_lkey;
            for (int p = 1; p < MAX_ENTRIES; p++) begin
                if (POS_W'(p) <= w_pos) begin
                    r_key[p] <= r_key[p-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= CNT_W'(1);
            for (int p = 0; p < MAX_ENTRIES; p++) begin
                r_slot[p] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_act == mrc_pkg::ACT_INVAL) begin
                for (int p = 0; p < MAX_ENTRIES; p++) begin
                    if (CNT_W'(p) < r_used) begin
                        r_valid[p] <= 1'b0;
                    end
                end
            end else begin
                r_valid[0] <= 1'b1;
                r_slot[0]  <= w_mslot;
                for (int p = 1; p < MAX_ENTRIES; p++) begin
                    if (POS_W'(p) <= w_pos) begin
                        r_valid[p] <= r_valid[p-1];
                        r_slot[p]  <= r_slot[p-1];
                    end
                end
                if (w_create) begin
                    r_used <= r_used + 1'b1;
                end
            end
        end
    end

    assign o_buffer_slot = r_out_slot;
    assign o_hit         = r_out_hit;

endmodule

>>> sv/mru_result_cache_lookup.sv
// Fully associative cache of up to MAX_ENTRIES result buffers kept in
// most-recently-used order. A lookup request returns the buffer slot for its
// key and a hit flag; a miss takes the first invalid entry, else creates a new
// slot while fewer than max_entries are in use, else replaces the last entry,
// and the chosen entry moves to the front. An invalidate request clears all
// valid bits and returns slot 0, miss. Each request passes three steps from
// acceptance to result: capture, compare against all stored keys in parallel,
// then select the entry and shift the entry line, which waits while an earlier
// result has not been taken. A new request is taken the cycle after the result
// is registered, so requests do not overlap. No clearing pass follows reset.
// max_entries may be written at any time the block is idle.
module mru_result_cache_lookup #(
    parameter int MAX_ENTRIES = mrc_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_WIDTH   = mrc_pkg::DEF_KEY_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrc_req_if.sink   i_req,
    mrc_res_if.source o_res,
    mrc_cfg_if.sink   i_cfg
);

    mrc_pkg::t_dp_cmd w_cmd;

    assign i_cfg.ready = 1'b1;

    mrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd)
    );

    mrc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_action      (i_req.action),
        .i_lookup_key  (i_req.lookup_key),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.max_entries),
        .o_buffer_slot (o_res.buffer_slot),
        .o_hit         (o_res.hit)
    );

endmodule
